[hw/rtl/bba_pkg.sv]
package bba_pkg;

    localparam int MIN_SHIFT        = 8;
    localparam int MIN_BLOCK_BYTES  = 1 << MIN_SHIFT;
    localparam int MAX_ORDER        = 10;
    localparam int FREE_QUEUE_DEPTH = 16;

    localparam int ACTION_W = 2;
    localparam int REQ_W    = 19;
    localparam int ALIGN_W  = 17;
    localparam int OFF_W    = 10;
    localparam int ORD_W    = 4;
    localparam int STATUS_W = 2;
    localparam int ABO_W    = 18;
    localparam int ADDR_W   = 64;
    localparam int REL_W    = 5;
    localparam int USED_W   = 19;

    localparam int POOL_UNITS = 1 << MAX_ORDER;
    localparam int POOL_BYTES = MIN_BLOCK_BYTES << MAX_ORDER;
    localparam int NODE_COUNT = (2 << MAX_ORDER) - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int BIT_W      = 5;
    localparam int ROW_BITS   = 1 << BIT_W;
    localparam int ROW_W      = NODE_W - BIT_W;
    localparam int ROWS       = (NODE_COUNT + ROW_BITS - 1) / ROW_BITS;
    localparam int BOFF_W     = OFF_W + MIN_SHIFT;
    localparam int AL_W       = BOFF_W + 1;
    localparam int DC_W       = $clog2(BOFF_W);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAN = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_QUEUE_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SR_RD,
        BK_SR_CHK,
        BK_MK_RD,
        BK_MK_WR,
        BK_SPLIT,
        BK_DIV,
        BK_ALN,
        BK_CL_RD,
        BK_CL_GET,
        BK_CL_NEXT,
        BK_REL_RD,
        BK_REL_CHK,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        action_t            action;
        logic [ORD_W-1:0]   ord;
        logic               too_big;
        logic [ALIGN_W-1:0] align;
        logic [OFF_W-1:0]   foff;
        logic [ORD_W-1:0]   ford;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [ORD_W-1:0]   block_order;
        logic [OFF_W-1:0]   unit_offset;
        logic [ABO_W-1:0]   aligned_byte_offset;
        logic [ADDR_W-1:0]  device_address;
        logic [REL_W-1:0]   blocks_released;
        logic [USED_W-1:0]  bytes_in_use;
    } res_t;

    // First node of an order in the flattened tree of free marks.
    function automatic logic [NODE_W-1:0] first_of(input logic [ORD_W-1:0] ord);
        logic [NODE_W:0] t;
        t = ((NODE_W+1)'(1) << (MAX_ORDER - int'(ord))) - (NODE_W+1)'(1);
        return t[NODE_W-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] last_of(input logic [ORD_W-1:0] ord);
        logic [NODE_W:0] t;
        t = ((NODE_W+1)'(2) << (MAX_ORDER - int'(ord))) - (NODE_W+1)'(2);
        return t[NODE_W-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                  input logic [OFF_W-1:0] off);
        logic [NODE_W-1:0] f;
        f = first_of(ord);
        return f + NODE_W'(off >> ord);
    endfunction

endpackage

[hw/rtl/bba_ram.sv]
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/bba_front.sv]
module bba_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bba_pkg::ACTION_W-1:0]  action,
    input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
    input  logic [bba_pkg::ALIGN_W-1:0]   alignment_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     free_unit_offset,
    input  logic [bba_pkg::ORD_W-1:0]     free_order,
    output logic                          cmd_valid,
    output bba_pkg::cmd_t                 cmd_out,
    input  logic                          cmd_pop
);

    localparam int NW = bba_pkg::REQ_W + 1;

    bba_pkg::cmd_t cmd_new;
    bba_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          pad;
    logic [NW-1:0] need;
    logic [NW-1:0] units;
    logic          accept;

    // Padding is needed unless the alignment is zero or a power of two that divides a minimum block.
    always_comb
    begin
        pad = (alignment_bytes != '0) &&
              !(((alignment_bytes & (alignment_bytes - 1'b1)) == '0) &&
                (alignment_bytes <= bba_pkg::ALIGN_W'(bba_pkg::MIN_BLOCK_BYTES)));
        need = pad ? ({1'b0, request_bytes} + NW'(alignment_bytes)) : {1'b0, request_bytes};
        units = (need + NW'(bba_pkg::MIN_BLOCK_BYTES - 1)) >> bba_pkg::MIN_SHIFT;
        cmd_new.action  = bba_pkg::action_t'(action);
        cmd_new.too_big = need > NW'(bba_pkg::POOL_BYTES);
        cmd_new.align   = alignment_bytes;
        cmd_new.foff    = free_unit_offset;
        cmd_new.ford    = free_order;
        cmd_new.ord     = '0;
        for (int k = 0; k < bba_pkg::MAX_ORDER; k++)
        begin
            if (units > (NW'(1) << k))
            begin
                cmd_new.ord = bba_pkg::ORD_W'(k + 1);
            end
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop && cmd_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(accept) - 2'(cmd_pop && cmd_valid);
        end
    end

endmodule

[hw/rtl/bba_back.sv]
module bba_back #(
    parameter int FREE_QUEUE_DEPTH = bba_pkg::FREE_QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  bba_pkg::cmd_t               cmd_in,
    output logic                        cmd_pop,
    input  logic [bba_pkg::ADDR_W-1:0]  base_address,
    output logic                        res_valid,
    output bba_pkg::res_t               res_out,
    input  logic                        res_ready
);

    localparam int QA_W  = (FREE_QUEUE_DEPTH > 1) ? $clog2(FREE_QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(FREE_QUEUE_DEPTH + 1);
    localparam int QE_W  = bba_pkg::OFF_W + bba_pkg::ORD_W;
    localparam int ORD_W = bba_pkg::ORD_W;
    localparam int OFF_W = bba_pkg::OFF_W;
    localparam int NODE_W = bba_pkg::NODE_W;
    localparam int ROW_W  = bba_pkg::ROW_W;
    localparam int BIT_W  = bba_pkg::BIT_W;
    localparam int RB     = bba_pkg::ROW_BITS;
    localparam int USED_W = bba_pkg::USED_W;
    localparam int ALIGN_W = bba_pkg::ALIGN_W;
    localparam int BOFF_W = bba_pkg::BOFF_W;
    localparam int AL_W   = bba_pkg::AL_W;
    localparam int DC_W   = bba_pkg::DC_W;

    bba_pkg::bk_state_t state_reg, state_next;
    bba_pkg::bk_state_t ret_reg, ret_next;
    bba_pkg::cmd_t      cmd_reg, cmd_next;
    bba_pkg::status_t   status_reg, status_next;
    logic [ORD_W-1:0]   j_reg, j_next;
    logic [ROW_W-1:0]   word_reg, word_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic               bitval_reg, bitval_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [QC_W-1:0]    qcnt_reg, qcnt_next;
    logic [QC_W-1:0]    idx_reg, idx_next;
    logic [QC_W-1:0]    rel_reg, rel_next;
    logic [DC_W-1:0]    divc_reg, divc_next;
    logic [ALIGN_W-1:0] rem_reg, rem_next;
    logic [AL_W-1:0]    aligned_reg, aligned_next;
    logic               alloc_ok_reg, alloc_ok_next;
    logic [bba_pkg::ROWS-1:0] valid_reg, valid_next;

    logic               mk_we, mk_re;
    logic [ROW_W-1:0]   mk_waddr, mk_raddr;
    logic [RB-1:0]      mk_wdata, mk_rdata, mk_word;
    logic               q_we, q_re;
    logic [QA_W-1:0]    q_waddr, q_raddr;
    logic [QE_W-1:0]    q_wdata, q_rdata;

    logic [NODE_W-1:0]  first_j, last_j, hnode, bnode, snode, selfnode;
    logic [NODE_W-1:0]  first_cmd, first_up;
    logic [RB-1:0]      hits;
    logic [BIT_W-1:0]   pb;
    logic [NODE_W-1:0]  idx_node;
    logic [BOFF_W-1:0]  boff;
    logic [ALIGN_W:0]   dv_t;
    logic [OFF_W-1:0]   e_off;
    logic [ORD_W-1:0]   e_ord;
    logic               e_ok;
    logic [USED_W-1:0]  e_sz, a_sz;
    logic [ORD_W-1:0]   jm1;

    bba_ram #(.WIDTH(RB), .DEPTH(bba_pkg::ROWS)) u_marks (
        .clk   (clk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .re    (mk_re),
        .raddr (mk_raddr),
        .rdata (mk_rdata)
    );

    bba_ram #(.WIDTH(QE_W), .DEPTH(FREE_QUEUE_DEPTH)) u_pend (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // A row never written holds its reset contents: only the whole-pool block is free.
    assign mk_word = valid_reg[row_reg] ? mk_rdata :
                     ((row_reg == '0) ? RB'(1) : '0);

    always_comb
    begin
        first_j   = bba_pkg::first_of(j_reg);
        last_j    = bba_pkg::last_of(j_reg);
        first_cmd = bba_pkg::first_of(cmd_in.ord);
        first_up  = bba_pkg::first_of(j_reg + 1'b1);
        jm1       = j_reg - 1'b1;
        bnode     = bba_pkg::node_of(j_reg, off_reg ^ (OFF_W'(1) << j_reg));
        snode     = bba_pkg::node_of(jm1, off_reg + (OFF_W'(1) << jm1));
        selfnode  = bba_pkg::node_of(j_reg, off_reg);
        for (int b = 0; b < RB; b++)
        begin
            idx_node = {word_reg, BIT_W'(b)};
            hits[b]  = mk_word[b] && (idx_node >= first_j) && (idx_node <= last_j);
        end
        pb = '0;
        for (int b = RB - 1; b >= 0; b--)
        begin
            if (hits[b])
            begin
                pb = BIT_W'(b);
            end
        end
        hnode = {word_reg, pb};
        boff  = {off_reg, {bba_pkg::MIN_SHIFT{1'b0}}};
        dv_t  = {rem_reg, boff[divc_reg]};
        e_off = q_rdata[QE_W-1:ORD_W];
        e_ord = q_rdata[ORD_W-1:0];
        e_ok  = (e_ord <= ORD_W'(bba_pkg::MAX_ORDER)) &&
                (32'(e_off) < bba_pkg::POOL_UNITS) &&
                ((16'(e_off) & ((16'(1) << e_ord) - 16'(1))) == 16'(0));
        e_sz  = USED_W'(bba_pkg::MIN_BLOCK_BYTES) << e_ord;
        a_sz  = USED_W'(bba_pkg::MIN_BLOCK_BYTES) << cmd_reg.ord;
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        j_next        = j_reg;
        word_next     = word_reg;
        row_next      = row_reg;
        off_next      = off_reg;
        node_next     = node_reg;
        bitval_next   = bitval_reg;
        used_next     = used_reg;
        qcnt_next     = qcnt_reg;
        idx_next      = idx_reg;
        rel_next      = rel_reg;
        divc_next     = divc_reg;
        rem_next      = rem_reg;
        aligned_next  = aligned_reg;
        alloc_ok_next = alloc_ok_reg;
        valid_next    = valid_reg;
        mk_we    = 1'b0;
        mk_waddr = node_reg[NODE_W-1:BIT_W];
        mk_wdata = mk_word;
        mk_re    = 1'b0;
        mk_raddr = word_reg;
        q_we     = 1'b0;
        q_waddr  = qcnt_reg[QA_W-1:0];
        q_wdata  = {cmd_in.foff, cmd_in.ford};
        q_re     = 1'b0;
        q_raddr  = idx_reg[QA_W-1:0];
        cmd_pop   = 1'b0;
        res_valid = 1'b0;

        case (state_reg)
            bba_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    cmd_next      = cmd_in;
                    status_next   = bba_pkg::ST_OK;
                    alloc_ok_next = 1'b0;
                    rel_next      = '0;
                    state_next    = bba_pkg::BK_DONE;
                    case (cmd_in.action)
                        bba_pkg::ACT_ALLOC:
                        begin
                            if (cmd_in.too_big ||
                                used_reg >= USED_W'(bba_pkg::POOL_BYTES))
                            begin
                                status_next = bba_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                j_next     = cmd_in.ord;
                                word_next  = first_cmd[NODE_W-1:BIT_W];
                                state_next = bba_pkg::BK_SR_RD;
                            end
                        end
                        bba_pkg::ACT_FREE:
                        begin
                            if (32'(qcnt_reg) < FREE_QUEUE_DEPTH)
                            begin
                                q_we      = 1'b1;
                                qcnt_next = qcnt_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = bba_pkg::ST_QUEUE_FULL;
                            end
                        end
                        bba_pkg::ACT_CLEAN:
                        begin
                            idx_next = '0;
                            if (qcnt_reg != '0)
                            begin
                                state_next = bba_pkg::BK_CL_RD;
                            end
                        end
                        default:
                        begin
                            state_next = bba_pkg::BK_DONE;
                        end
                    endcase
                end
            end

            bba_pkg::BK_SR_RD:
            begin
                mk_re      = 1'b1;
                mk_raddr   = word_reg;
                row_next   = word_reg;
                state_next = bba_pkg::BK_SR_CHK;
            end

            bba_pkg::BK_SR_CHK:
            begin
                if (hits != '0)
                begin
                    // Take the block and clear its mark right away from the word in hand.
                    off_next   = OFF_W'((hnode - first_j) << j_reg);
                    mk_we      = 1'b1;
                    mk_waddr   = word_reg;
                    mk_wdata   = mk_word & ~(RB'(1) << pb);
                    state_next = bba_pkg::BK_SPLIT;
                end
                else if (word_reg == last_j[NODE_W-1:BIT_W])
                begin
                    if (j_reg == ORD_W'(bba_pkg::MAX_ORDER))
                    begin
                        status_next = bba_pkg::ST_NO_SPACE;
                        state_next  = bba_pkg::BK_DONE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        word_next  = first_up[NODE_W-1:BIT_W];
                        state_next = bba_pkg::BK_SR_RD;
                    end
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = bba_pkg::BK_SR_RD;
                end
            end

            bba_pkg::BK_MK_RD:
            begin
                mk_re      = 1'b1;
                mk_raddr   = node_reg[NODE_W-1:BIT_W];
                row_next   = node_reg[NODE_W-1:BIT_W];
                state_next = bba_pkg::BK_MK_WR;
            end

            bba_pkg::BK_MK_WR:
            begin
                mk_we      = 1'b1;
                mk_waddr   = node_reg[NODE_W-1:BIT_W];
                mk_wdata   = mk_word;
                mk_wdata[node_reg[BIT_W-1:0]] = bitval_reg;
                state_next = ret_reg;
            end

            bba_pkg::BK_SPLIT:
            begin
                if (j_reg > cmd_reg.ord)
                begin
                    // The right half of each split stays free.
                    j_next      = jm1;
                    node_next   = snode;
                    bitval_next = 1'b1;
                    ret_next    = bba_pkg::BK_SPLIT;
                    state_next  = bba_pkg::BK_MK_RD;
                end
                else
                begin
                    used_next = used_reg + a_sz;
                    if (cmd_reg.align == '0)
                    begin
                        aligned_next  = {1'b0, boff};
                        alloc_ok_next = 1'b1;
                        state_next    = bba_pkg::BK_DONE;
                    end
                    else
                    begin
                        divc_next  = DC_W'(BOFF_W - 1);
                        rem_next   = '0;
                        state_next = bba_pkg::BK_DIV;
                    end
                end
            end

            bba_pkg::BK_DIV:
            begin
                // One dividend bit per cycle, most significant first.
                if (dv_t >= {1'b0, cmd_reg.align})
                begin
                    rem_next = ALIGN_W'(dv_t - {1'b0, cmd_reg.align});
                end
                else
                begin
                    rem_next = ALIGN_W'(dv_t);
                end
                if (divc_reg == '0)
                begin
                    state_next = bba_pkg::BK_ALN;
                end
                else
                begin
                    divc_next = divc_reg - 1'b1;
                end
            end

            bba_pkg::BK_ALN:
            begin
                if (rem_reg == '0)
                begin
                    aligned_next = {1'b0, boff};
                end
                else
                begin
                    aligned_next = {1'b0, boff} + AL_W'(cmd_reg.align - rem_reg);
                end
                alloc_ok_next = 1'b1;
                state_next    = bba_pkg::BK_DONE;
            end

            bba_pkg::BK_CL_RD:
            begin
                q_re       = 1'b1;
                state_next = bba_pkg::BK_CL_GET;
            end

            bba_pkg::BK_CL_GET:
            begin
                if (e_ok)
                begin
                    off_next   = e_off;
                    j_next     = e_ord;
                    used_next  = (used_reg >= e_sz) ? (used_reg - e_sz) : '0;
                    rel_next   = rel_reg + 1'b1;
                    state_next = bba_pkg::BK_REL_RD;
                end
                else
                begin
                    state_next = bba_pkg::BK_CL_NEXT;
                end
            end

            bba_pkg::BK_CL_NEXT:
            begin
                if (idx_reg + 1'b1 == qcnt_reg)
                begin
                    qcnt_next  = '0;
                    state_next = bba_pkg::BK_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = bba_pkg::BK_CL_RD;
                end
            end

            bba_pkg::BK_REL_RD:
            begin
                if (j_reg < ORD_W'(bba_pkg::MAX_ORDER))
                begin
                    node_next  = bnode;
                    mk_re      = 1'b1;
                    mk_raddr   = bnode[NODE_W-1:BIT_W];
                    row_next   = bnode[NODE_W-1:BIT_W];
                    state_next = bba_pkg::BK_REL_CHK;
                end
                else
                begin
                    node_next   = selfnode;
                    bitval_next = 1'b1;
                    ret_next    = bba_pkg::BK_CL_NEXT;
                    state_next  = bba_pkg::BK_MK_RD;
                end
            end

            bba_pkg::BK_REL_CHK:
            begin
                if (mk_word[node_reg[BIT_W-1:0]])
                begin
                    // Buddy is free: absorb it and go one order up.
                    mk_we    = 1'b1;
                    mk_waddr = node_reg[NODE_W-1:BIT_W];
                    mk_wdata = mk_word & ~(RB'(1) << node_reg[BIT_W-1:0]);
                    off_next = off_reg & ~(OFF_W'(1) << j_reg);
                    j_next   = j_reg + 1'b1;
                    state_next = bba_pkg::BK_REL_RD;
                end
                else
                begin
                    node_next   = selfnode;
                    bitval_next = 1'b1;
                    ret_next    = bba_pkg::BK_CL_NEXT;
                    state_next  = bba_pkg::BK_MK_RD;
                end
            end

            bba_pkg::BK_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bba_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::BK_IDLE;
            end
        endcase

        if (mk_we)
        begin
            valid_next[mk_waddr] = 1'b1;
        end
    end

    always_comb
    begin
        res_out.status              = status_reg;
        res_out.block_order         = alloc_ok_reg ? cmd_reg.ord : '0;
        res_out.unit_offset         = alloc_ok_reg ? off_reg : '0;
        res_out.aligned_byte_offset = alloc_ok_reg ? aligned_reg[bba_pkg::ABO_W-1:0] : '0;
        res_out.device_address      = alloc_ok_reg ?
                                      (base_address + bba_pkg::ADDR_W'(aligned_reg)) : '0;
        res_out.blocks_released     = (cmd_reg.action == bba_pkg::ACT_CLEAN) ?
                                      bba_pkg::REL_W'(rel_reg) : '0;
        res_out.bytes_in_use        = used_reg;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        word_reg    <= word_next;
        row_reg     <= row_next;
        off_reg     <= off_next;
        node_reg    <= node_next;
        bitval_reg  <= bitval_next;
        idx_reg     <= idx_next;
        divc_reg    <= divc_next;
        rem_reg     <= rem_next;
        aligned_reg <= aligned_next;
        ret_reg     <= ret_next;
        j_reg       <= j_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bba_pkg::BK_IDLE;
            status_reg   <= bba_pkg::ST_OK;
            used_reg     <= '0;
            qcnt_reg     <= '0;
            rel_reg      <= '0;
            alloc_ok_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            used_reg     <= used_next;
            qcnt_reg     <= qcnt_next;
            rel_reg      <= rel_next;
            alloc_ok_reg <= alloc_ok_next;
            valid_reg    <= valid_next;
        end
    end

endmodule

[hw/rtl/buddy_block_allocator.sv]
// Channel   Handshake                      Payload
// input     push / full                    action, request_bytes, alignment_bytes,
//                                          free_unit_offset, free_order
// result    empty / pop                    status, block_order, unit_offset,
//                                          aligned_byte_offset, device_address,
//                                          blocks_released, bytes_in_use
// config    cfg_valid / cfg_ready          base_address
//
// Items are carried out one at a time by a sequencer over a free-mark RAM of 32-bit rows.
// An allocation scans rows across the candidate orders, then splits the block it takes,
// and runs the remainder divider when a nonzero alignment needs it; cleanup drops bad
// entries and applies the rest, merging buddies level by level.
// Reset is usable at once: rows never written read as their reset contents.
// A two-item front queue takes items, until it is full, while the sequencer or the result register stalls.
module buddy_block_allocator #(
    parameter int FREE_QUEUE_DEPTH = bba_pkg::FREE_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bba_pkg::ACTION_W-1:0]  action,
    input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
    input  logic [bba_pkg::ALIGN_W-1:0]   alignment_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     free_unit_offset,
    input  logic [bba_pkg::ORD_W-1:0]     free_order,
    output logic                          empty,
    input  logic                          pop,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    output logic [bba_pkg::ORD_W-1:0]     block_order,
    output logic [bba_pkg::OFF_W-1:0]     unit_offset,
    output logic [bba_pkg::ABO_W-1:0]     aligned_byte_offset,
    output logic [bba_pkg::ADDR_W-1:0]    device_address,
    output logic [bba_pkg::REL_W-1:0]     blocks_released,
    output logic [bba_pkg::USED_W-1:0]    bytes_in_use,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::ADDR_W-1:0]    base_address
);

    logic                        cmd_valid;
    logic                        cmd_pop;
    bba_pkg::cmd_t               cmd;
    logic                        bk_res_valid;
    logic                        bk_res_ready;
    bba_pkg::res_t               bk_res;
    bba_pkg::res_t               res_reg;
    logic                        res_full_reg;
    logic [bba_pkg::ADDR_W-1:0]  base_reg;

    bba_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .action           (action),
        .request_bytes    (request_bytes),
        .alignment_bytes  (alignment_bytes),
        .free_unit_offset (free_unit_offset),
        .free_order       (free_order),
        .cmd_valid        (cmd_valid),
        .cmd_out          (cmd),
        .cmd_pop          (cmd_pop)
    );

    bba_back #(.FREE_QUEUE_DEPTH(FREE_QUEUE_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_in       (cmd),
        .cmd_pop      (cmd_pop),
        .base_address (base_reg),
        .res_valid    (bk_res_valid),
        .res_out      (bk_res),
        .res_ready    (bk_res_ready)
    );

    assign cfg_ready    = 1'b1;
    assign bk_res_ready = !res_full_reg || pop;
    assign empty        = !res_full_reg;

    assign status              = res_reg.status;
    assign block_order         = res_reg.block_order;
    assign unit_offset         = res_reg.unit_offset;
    assign aligned_byte_offset = res_reg.aligned_byte_offset;
    assign device_address      = res_reg.device_address;
    assign blocks_released     = res_reg.blocks_released;
    assign bytes_in_use        = res_reg.bytes_in_use;

    always_ff @(posedge clk)
    begin
        if (bk_res_valid && bk_res_ready)
        begin
            res_reg <= bk_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_full_reg <= 1'b0;
            base_reg     <= '0;
        end
        else
        begin
            if (bk_res_valid && bk_res_ready)
            begin
                res_full_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_full_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= base_address;
            end
        end
    end

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != bba_pkg::ST_OK) |->
            (block_order == '0 && unit_offset == '0 && device_address == '0))
        else $error("failed item carries allocation fields");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (block_order <= bba_pkg::ORD_W'(bba_pkg::MAX_ORDER)))
        else $error("block order out of range");

    a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((unit_offset & ((bba_pkg::OFF_W'(1) << block_order) - 1'b1)) == '0))
        else $error("unit offset not aligned to its block order");

endmodule
